>>> hdl/amr_fnt_pkg.sv
// Package for the quadtree face-neighbor test block.
// Holds field widths, word layout, register indexes, face and relation codes,
// and the width helpers. No dependencies.
package amr_fnt_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_LEVEL_DEF = 15;
  localparam int ROOT_BITS_DEF = 10;

  // Fixed field widths.
  localparam int LVL_W      = 4;
  localparam int IDX_W      = 25;
  localparam int CFG_W      = 11;
  localparam int CFG_ADDR_W = 4;

  // Input word layout, lowest bit first.
  localparam int IN_FACE_LSB  = 0;
  localparam int IN_AL_LSB    = 2;
  localparam int IN_AX_LSB    = 6;
  localparam int IN_AY_LSB    = 31;
  localparam int IN_BL_LSB    = 56;
  localparam int IN_BX_LSB    = 60;
  localparam int IN_BY_LSB    = 85;
  localparam int IN_SAME_BIT  = 110;
  localparam int IN_USED_W    = 111;
  localparam int IN_DATA_W    = 112;

  // Output word layout.
  localparam int OUT_DIRECT_BIT = 0;
  localparam int OUT_WRAP_BIT   = 1;
  localparam int OUT_REL_LSB    = 2;
  localparam int OUT_DATA_W     = 8;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_ROOT_X = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ROOT_Y = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WRAP_X = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_WRAP_Y = 4'd3;

  // Face codes of block a.
  localparam logic [1:0] FACE_XM = 2'd0;
  localparam logic [1:0] FACE_XP = 2'd1;
  localparam logic [1:0] FACE_YM = 2'd2;
  localparam logic [1:0] FACE_YP = 2'd3;

  // Level of b relative to a.
  localparam logic [1:0] REL_SAME    = 2'd0;
  localparam logic [1:0] REL_COARSER = 2'd1;
  localparam logic [1:0] REL_FINER   = 2'd2;

  // Per-pair control flags passed from the scaling to the matching logic.
  typedef struct packed {
    logic self_pair;
    logic periodic;
  } fnt_ctl_t;

  // Highest level that the four-bit level field can reach after saturation.
  function automatic int eff_level(int max_level);
    eff_level = (max_level < 15) ? max_level : 15;
  endfunction

  // Width of a scaled coordinate (start of a range).
  function automatic int coord_w(int max_level);
    coord_w = IDX_W + eff_level(max_level);
  endfunction

  // Width of the domain span at the finest level.
  function automatic int span_w(int max_level, int root_bits);
    span_w = root_bits + 1 + eff_level(max_level);
  endfunction

endpackage

>>> hdl/amr_fnt_scale.sv
// Level alignment and range scaling for one block pair.
// Picks normal and tangential ranges for the face and the periodic span.
// Depends on amr_fnt_pkg.
module amr_fnt_scale #(
  parameter int MAX_LEVEL = amr_fnt_pkg::MAX_LEVEL_DEF,
  parameter int ROOT_BITS = amr_fnt_pkg::ROOT_BITS_DEF
) (
  input  logic [1:0]                                    face,
  input  logic [amr_fnt_pkg::LVL_W-1:0]                 a_level,
  input  logic [amr_fnt_pkg::IDX_W-1:0]                 a_x,
  input  logic [amr_fnt_pkg::IDX_W-1:0]                 a_y,
  input  logic [amr_fnt_pkg::LVL_W-1:0]                 b_level,
  input  logic [amr_fnt_pkg::IDX_W-1:0]                 b_x,
  input  logic [amr_fnt_pkg::IDX_W-1:0]                 b_y,
  input  logic                                          self_pair,
  input  logic [amr_fnt_pkg::CFG_W-1:0]                 root_x,
  input  logic [amr_fnt_pkg::CFG_W-1:0]                 root_y,
  input  logic                                          wrap_x,
  input  logic                                          wrap_y,
  output logic [amr_fnt_pkg::coord_w(MAX_LEVEL):0]      norm_a,
  output logic [amr_fnt_pkg::coord_w(MAX_LEVEL):0]      norm_b,
  output logic [amr_fnt_pkg::coord_w(MAX_LEVEL):0]      tan_a_lo,
  output logic [amr_fnt_pkg::coord_w(MAX_LEVEL):0]      tan_a_end,
  output logic [amr_fnt_pkg::coord_w(MAX_LEVEL):0]      tan_b_lo,
  output logic [amr_fnt_pkg::coord_w(MAX_LEVEL):0]      tan_b_end,
  output logic [amr_fnt_pkg::span_w(MAX_LEVEL, ROOT_BITS)-1:0] span,
  output amr_fnt_pkg::fnt_ctl_t                         ctl,
  output logic [1:0]                                    relation
);

  localparam int EL  = amr_fnt_pkg::eff_level(MAX_LEVEL);
  localparam int CW  = amr_fnt_pkg::coord_w(MAX_LEVEL);
  localparam int WW  = amr_fnt_pkg::span_w(MAX_LEVEL, ROOT_BITS);
  localparam int RW  = ROOT_BITS + 1;
  localparam int RCW = (RW > amr_fnt_pkg::CFG_W) ? RW : amr_fnt_pkg::CFG_W;
  localparam logic [amr_fnt_pkg::LVL_W-1:0] LVL_CAP = amr_fnt_pkg::LVL_W'(EL);
  localparam logic [RCW-1:0] ROOT_CAP = RCW'(1) << ROOT_BITS;

  logic [amr_fnt_pkg::LVL_W-1:0] al, bl, lc, sh_a, sh_b;
  logic          xface, minus;
  logic [CW:0]   ax_lo, ax_end, ay_lo, ay_end;
  logic [CW:0]   bx_lo, bx_end, by_lo, by_end;
  logic [RCW-1:0] root_n, root_sat;

  // Saturate both levels and find the finer one.
  always_comb begin
    al   = (a_level > LVL_CAP) ? LVL_CAP : a_level;
    bl   = (b_level > LVL_CAP) ? LVL_CAP : b_level;
    lc   = (al > bl) ? al : bl;
    sh_a = lc - al;
    sh_b = lc - bl;
  end

  // Scale each index to its range at the finer level; the end is one past the range.
  always_comb begin
    ax_lo  = (CW+1)'(a_x) << sh_a;
    ax_end = ((CW+1)'(a_x) + (CW+1)'(1)) << sh_a;
    ay_lo  = (CW+1)'(a_y) << sh_a;
    ay_end = ((CW+1)'(a_y) + (CW+1)'(1)) << sh_a;
    bx_lo  = (CW+1)'(b_x) << sh_b;
    bx_end = ((CW+1)'(b_x) + (CW+1)'(1)) << sh_b;
    by_lo  = (CW+1)'(b_y) << sh_b;
    by_end = ((CW+1)'(b_y) + (CW+1)'(1)) << sh_b;
  end

  // On a minus face, a's start meets b's end; on a plus face, a's end meets b's start.
  always_comb begin
    xface = (face == amr_fnt_pkg::FACE_XM) || (face == amr_fnt_pkg::FACE_XP);
    minus = (face == amr_fnt_pkg::FACE_XM) || (face == amr_fnt_pkg::FACE_YM);
    if (xface) begin
      norm_a    = minus ? ax_lo  : ax_end;
      norm_b    = minus ? bx_end : bx_lo;
      tan_a_lo  = ay_lo;
      tan_a_end = ay_end;
      tan_b_lo  = by_lo;
      tan_b_end = by_end;
    end else begin
      norm_a    = minus ? ay_lo  : ay_end;
      norm_b    = minus ? by_end : by_lo;
      tan_a_lo  = ax_lo;
      tan_a_end = ax_end;
      tan_b_lo  = bx_lo;
      tan_b_end = bx_end;
    end
  end

  // Domain span along the face normal, at the finer level.
  always_comb begin
    root_n   = xface ? RCW'(root_x) : RCW'(root_y);
    root_sat = (root_n > ROOT_CAP) ? ROOT_CAP : root_n;
    span     = WW'(root_sat[RW-1:0]) << lc;
  end

  // Pair flags and the level relation.
  always_comb begin
    ctl.self_pair = self_pair;
    ctl.periodic  = xface ? wrap_x : wrap_y;
    if (bl == al) begin
      relation = amr_fnt_pkg::REL_SAME;
    end else if (bl < al) begin
      relation = amr_fnt_pkg::REL_COARSER;
    end else begin
      relation = amr_fnt_pkg::REL_FINER;
    end
  end

endmodule

>>> hdl/amr_fnt_match.sv
// Adjacency compares for one block pair: direct, and shifted by the span
// down and up for the periodic case. Depends on amr_fnt_pkg.
module amr_fnt_match #(
  parameter int MAX_LEVEL = amr_fnt_pkg::MAX_LEVEL_DEF,
  parameter int ROOT_BITS = amr_fnt_pkg::ROOT_BITS_DEF
) (
  input  logic [amr_fnt_pkg::coord_w(MAX_LEVEL):0]      norm_a,
  input  logic [amr_fnt_pkg::coord_w(MAX_LEVEL):0]      norm_b,
  input  logic [amr_fnt_pkg::coord_w(MAX_LEVEL):0]      tan_a_lo,
  input  logic [amr_fnt_pkg::coord_w(MAX_LEVEL):0]      tan_a_end,
  input  logic [amr_fnt_pkg::coord_w(MAX_LEVEL):0]      tan_b_lo,
  input  logic [amr_fnt_pkg::coord_w(MAX_LEVEL):0]      tan_b_end,
  input  logic [amr_fnt_pkg::span_w(MAX_LEVEL, ROOT_BITS)-1:0] span,
  input  amr_fnt_pkg::fnt_ctl_t                         ctl,
  output logic                                          touches_direct,
  output logic                                          touches_wrapped
);

  localparam int CW = amr_fnt_pkg::coord_w(MAX_LEVEL);
  localparam int WW = amr_fnt_pkg::span_w(MAX_LEVEL, ROOT_BITS);
  localparam int SW = ((CW + 1 > WW) ? CW + 1 : WW) + 1;

  logic [SW-1:0] pe, qe, we;
  logic          hit_0, hit_dn, hit_up, tan_ov;

  // Normal-axis contact with b unshifted, shifted down and shifted up by the span.
  always_comb begin
    pe     = SW'(norm_a);
    qe     = SW'(norm_b);
    we     = SW'(span);
    hit_0  = (pe == qe);
    hit_dn = ((pe + we) == qe);
    hit_up = ((qe + we) == pe);
  end

  // Tangential overlap on half-open ranges.
  assign tan_ov = (tan_a_lo < tan_b_end) && (tan_b_lo < tan_a_end);

  assign touches_direct  = !ctl.self_pair && tan_ov && hit_0;
  assign touches_wrapped = ctl.periodic && tan_ov && (hit_dn || hit_up);

endmodule

>>> hdl/amr_face_neighbor_test_core.sv
// Quadtree face-neighbor test, top level. Depends on amr_fnt_pkg, amr_fnt_scale, amr_fnt_match.
// The word passes through the input register and then the result register on its way to the result word.
// Throughput: one word per cycle while out_tready is high; the scaling and compare logic between the two registers
// is a single pass, and while a result waits the input register still takes a new word if it is empty.
// Reset (rst_n low, synchronous) empties both stages and sets root counts to 1, wrap off.
module amr_face_neighbor_test_core #(
  parameter int MAX_LEVEL = amr_fnt_pkg::MAX_LEVEL_DEF,
  parameter int ROOT_BITS = amr_fnt_pkg::ROOT_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Configuration write port.
  input  logic                                   cfg_we,
  input  logic [amr_fnt_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [amr_fnt_pkg::CFG_W-1:0]          cfg_wdata,
  // Input stream.
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // face[1:0], a_level[5:2], a_x[30:6], a_y[55:31], b_level[59:56],
  // b_x[84:60], b_y[109:85], self_pair[110], zero pad[111]
  input  logic [amr_fnt_pkg::IN_DATA_W-1:0]      in_tdata,
  // Result stream.
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // touches_direct[0], touches_wrapped[1], relation[3:2], zero pad[7:4]
  output logic [amr_fnt_pkg::OUT_DATA_W-1:0]     out_tdata
);

  localparam int CW = amr_fnt_pkg::coord_w(MAX_LEVEL);
  localparam int WW = amr_fnt_pkg::span_w(MAX_LEVEL, ROOT_BITS);
  localparam int LW = amr_fnt_pkg::LVL_W;
  localparam int XW = amr_fnt_pkg::IDX_W;

  // Configuration registers.
  logic [amr_fnt_pkg::CFG_W-1:0] root_x_r, root_y_r;
  logic                          wrap_x_r, wrap_y_r;

  // Pipeline registers.
  logic                                  s1_valid_r, s1_valid_nxt;
  logic [amr_fnt_pkg::IN_USED_W-1:0]     s1_data_r;
  logic                                  out_valid_r, out_valid_nxt;
  logic [amr_fnt_pkg::OUT_DATA_W-1:0]    out_data_r, out_data_nxt;
  logic                                  out_adv, s1_adv;

  // Between the scaling and compare logic.
  logic [CW:0]   norm_a, norm_b, tan_a_lo, tan_a_end, tan_b_lo, tan_b_end;
  logic [WW-1:0] span;
  amr_fnt_pkg::fnt_ctl_t ctl;
  logic [1:0]    relation;
  logic          touches_direct, touches_wrapped;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_x_r <= amr_fnt_pkg::CFG_W'(1);
      root_y_r <= amr_fnt_pkg::CFG_W'(1);
      wrap_x_r <= 1'b0;
      wrap_y_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        amr_fnt_pkg::REG_ROOT_X: root_x_r <= cfg_wdata;
        amr_fnt_pkg::REG_ROOT_Y: root_y_r <= cfg_wdata;
        amr_fnt_pkg::REG_WRAP_X: wrap_x_r <= cfg_wdata[0];
        amr_fnt_pkg::REG_WRAP_Y: wrap_y_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Flow control: each stage moves when the one after it can take its word.
  assign out_adv   = !out_valid_r || out_tready;
  assign s1_adv    = !s1_valid_r || out_adv;
  assign in_tready = s1_adv;

  always_comb begin
    s1_valid_nxt  = s1_adv ? in_tvalid : s1_valid_r;
    out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;
  end

  // Control state of both stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_tvalid && s1_adv) begin
      s1_data_r <= in_tdata[amr_fnt_pkg::IN_USED_W-1:0];
    end
  end

  // Scaling of both blocks to the finer level.
  amr_fnt_scale #(
    .MAX_LEVEL (MAX_LEVEL),
    .ROOT_BITS (ROOT_BITS)
  ) u_scale (
    .face       (s1_data_r[amr_fnt_pkg::IN_FACE_LSB +: 2]),
    .a_level    (s1_data_r[amr_fnt_pkg::IN_AL_LSB +: LW]),
    .a_x        (s1_data_r[amr_fnt_pkg::IN_AX_LSB +: XW]),
    .a_y        (s1_data_r[amr_fnt_pkg::IN_AY_LSB +: XW]),
    .b_level    (s1_data_r[amr_fnt_pkg::IN_BL_LSB +: LW]),
    .b_x        (s1_data_r[amr_fnt_pkg::IN_BX_LSB +: XW]),
    .b_y        (s1_data_r[amr_fnt_pkg::IN_BY_LSB +: XW]),
    .self_pair  (s1_data_r[amr_fnt_pkg::IN_SAME_BIT]),
    .root_x     (root_x_r),
    .root_y     (root_y_r),
    .wrap_x     (wrap_x_r),
    .wrap_y     (wrap_y_r),
    .norm_a     (norm_a),
    .norm_b     (norm_b),
    .tan_a_lo   (tan_a_lo),
    .tan_a_end  (tan_a_end),
    .tan_b_lo   (tan_b_lo),
    .tan_b_end  (tan_b_end),
    .span       (span),
    .ctl        (ctl),
    .relation   (relation)
  );

  // Adjacency compares.
  amr_fnt_match #(
    .MAX_LEVEL (MAX_LEVEL),
    .ROOT_BITS (ROOT_BITS)
  ) u_match (
    .norm_a          (norm_a),
    .norm_b          (norm_b),
    .tan_a_lo        (tan_a_lo),
    .tan_a_end       (tan_a_end),
    .tan_b_lo        (tan_b_lo),
    .tan_b_end       (tan_b_end),
    .span            (span),
    .ctl             (ctl),
    .touches_direct  (touches_direct),
    .touches_wrapped (touches_wrapped)
  );

  // Result word assembly.
  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[amr_fnt_pkg::OUT_DIRECT_BIT]  = touches_direct;
    out_data_nxt[amr_fnt_pkg::OUT_WRAP_BIT]    = touches_wrapped;
    out_data_nxt[amr_fnt_pkg::OUT_REL_LSB +: 2] = relation;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A word in the input register moves on whenever the result register frees up.
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_adv |=> out_valid_r)
    else $error("input stage word was not moved to the result register");

  // A pair marked as the same block never reports direct contact.
  a_same_no_direct: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_adv && s1_data_r[amr_fnt_pkg::IN_SAME_BIT]
    |=> !out_tdata[amr_fnt_pkg::OUT_DIRECT_BIT])
    else $error("direct contact reported for the same block");

  // With no periodic axis, no wrapped contact can appear.
  a_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_adv && !wrap_x_r && !wrap_y_r
    |=> !out_tdata[amr_fnt_pkg::OUT_WRAP_BIT])
    else $error("wrapped contact reported with both axes non-periodic");

endmodule
